### hdl/ascp_pkg.sv
// ----------------------------------------------------------------------------
// ascp_pkg
// Shared types, constants and helper functions of the ASCII to unsigned parser.
// ----------------------------------------------------------------------------
package ascp_pkg;

  localparam int OFFSET_WIDTH  = 16;
  localparam int VALUE_WIDTH   = 64;
  localparam int BASE_WIDTH    = 6;
  localparam int CHAR_WIDTH    = 8;
  localparam int RESULT_OFFSET_WIDTH = 16;
  localparam int PROD_WIDTH    = VALUE_WIDTH + BASE_WIDTH;
  localparam int PADDR_WIDTH   = 3;
  localparam int PDATA_WIDTH   = 32;

  typedef logic [CHAR_WIDTH-1:0]   char_t;
  typedef logic [BASE_WIDTH-1:0]   base_t;
  typedef logic [VALUE_WIDTH-1:0]  value_t;
  typedef logic [OFFSET_WIDTH-1:0] pos_t;

  // Character codes
  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_NL    = 8'h0A;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_UA    = 8'h41;
  localparam char_t CH_UZ    = 8'h5A;
  localparam char_t CH_LA    = 8'h61;
  localparam char_t CH_LZ    = 8'h7A;
  localparam char_t CH_UX    = 8'h58;
  localparam char_t CH_LX    = 8'h78;
  localparam char_t LETTER_OFFSET = 8'd10;

  // Bases
  localparam base_t BASE_DETECT = 6'd0;
  localparam base_t BASE_OCT    = 6'd8;
  localparam base_t BASE_DEC    = 6'd10;
  localparam base_t BASE_HEX    = 6'd16;

  localparam pos_t   POS_MAX   = '1;
  localparam value_t VALUE_MAX = '1;

  // Register index, taken from paddr[2]
  localparam logic REG_BASE_SETTING = 1'b0;

  typedef enum logic [2:0] {
    PH_DONE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    char_t char_code;
    logic  start_of_string;
  } char_item_t;

  typedef struct packed {
    value_t                         value;
    logic [RESULT_OFFSET_WIDTH-1:0] end_offset;
    logic                           overflowed;
  } result_item_t;

  typedef struct packed {
    phase_t phase;
    value_t accumulator;
    logic   minus_seen;
    base_t  active_base;
    pos_t   char_position;
  } parse_state_t;

  typedef struct packed {
    logic  valid;
    base_t value;
  } digit_t;

  function automatic digit_t digit_decode(input char_t c);
    digit_t d;
    d.valid = 1'b1;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.value = BASE_WIDTH'(c - CH_ZERO);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d.value = BASE_WIDTH'(c - CH_UA + LETTER_OFFSET);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d.value = BASE_WIDTH'(c - CH_LA + LETTER_OFFSET);
    end else begin
      d.valid = 1'b0;
      d.value = '0;
    end
    return d;
  endfunction

  function automatic logic [RESULT_OFFSET_WIDTH-1:0] offset_out(input pos_t p);
    logic [31:0] w;
    w = 32'(p);
    return w[RESULT_OFFSET_WIDTH-1:0];
  endfunction

endpackage

### hdl/ascii_to_unsigned_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_to_unsigned_parser_core
// Streaming strtoul-style parser: one character per transaction, at most one
// result per string with value, end offset and overflow flag.
//
//   channel  direction  handshake                  payload
//   char     in         char_valid / char_ready    char_data   (char_item_t)
//   result   out        result_valid / result_ready result_data (result_item_t)
//   config   in         APB psel/penable/pready    base_setting at 0x0
//
// One character per cycle sustained unless a result stalls; a character is
// held in the input register, and its result is then loaded into the result
// register. The 64x6 multiply-add of the digit step sets the cycle time. Reset
// clears parse state and the base setting. A stalled result only holds back a
// character that would end a parse; other characters keep flowing past it.
// ----------------------------------------------------------------------------
module ascii_to_unsigned_parser_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             char_valid,
  output logic                             char_ready,
  input  ascp_pkg::char_item_t             char_data,
  output logic                             result_valid,
  input  logic                             result_ready,
  output ascp_pkg::result_item_t           result_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ascp_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [ascp_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [ascp_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                             pready
);
  import ascp_pkg::*;

  base_t        base_setting;
  char_item_t   in_item;
  logic         in_full;
  parse_state_t st;
  parse_state_t st_next;
  logic         step_emit;
  result_item_t step_result;
  logic         out_free;
  logic         step_fire;

  ascp_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .base_setting (base_setting)
  );

  ascp_step u_step (
    .cur          (st),
    .item         (in_item),
    .base_setting (base_setting),
    .next         (st_next),
    .emit         (step_emit),
    .result       (step_result)
  );

  // a character that ends no parse never waits on the result side
  assign step_fire  = in_full && (!step_emit || out_free);
  assign char_ready = !in_full || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (char_valid && char_ready) begin
      in_full <= 1'b1;
    end else if (step_fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      in_item <= char_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_DONE;
      st.accumulator   <= '0;
      st.minus_seen    <= 1'b0;
      st.active_base   <= BASE_DETECT;
      st.char_position <= '0;
    end else if (step_fire) begin
      st <= st_next;
    end
  end

  ascp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step_fire && step_emit),
    .load_data (step_result),
    .ready     (result_ready),
    .valid     (result_valid),
    .data      (result_data),
    .free      (out_free)
  );

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    in_full && !result_valid |-> step_fire)
    else $error("held character not processed while result slot empty");

  a_done_after_emit: assert property (@(posedge clk) disable iff (rst)
    step_fire && step_emit |=> st.phase == PH_DONE)
    else $error("parse not closed after result");

  a_overflow_all_ones: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.overflowed |-> &result_data.value)
    else $error("overflow result without all-ones value");

  a_done_ignores: assert property (@(posedge clk) disable iff (rst)
    step_fire && st.phase == PH_DONE && !in_item.start_of_string |-> !step_emit)
    else $error("result from a character outside any parse");

endmodule

### hdl/ascp_cfg.sv
// ----------------------------------------------------------------------------
// ascp_cfg
// APB register slave holding the base setting.
// ----------------------------------------------------------------------------
module ascp_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ascp_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [ascp_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [ascp_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                          pready,
  output ascp_pkg::base_t               base_setting
);
  import ascp_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_BASE_SETTING);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_setting <= BASE_DETECT;
    end else if (wr_en) begin
      base_setting <= pwdata[BASE_WIDTH-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_BASE_SETTING) begin
      prdata = PDATA_WIDTH'(base_setting);
    end else begin
      prdata = '0;
    end
  end

endmodule

### hdl/ascp_step.sv
// ----------------------------------------------------------------------------
// ascp_step
// Next-state and result logic for one character: skip, sign, prefix, digit.
// ----------------------------------------------------------------------------
module ascp_step (
  input  ascp_pkg::parse_state_t cur,
  input  ascp_pkg::char_item_t   item,
  input  ascp_pkg::base_t        base_setting,
  output ascp_pkg::parse_state_t next,
  output logic                   emit,
  output ascp_pkg::result_item_t result
);
  import ascp_pkg::*;

  parse_state_t          s;
  logic                  handled;
  logic                  do_advance;
  char_t                 c;
  digit_t                dg;
  logic [PROD_WIDTH-1:0] prod;
  logic [VALUE_WIDTH:0]  sum;
  pos_t                  pos_inc;

  assign c  = item.char_code;
  assign dg = digit_decode(c);

  always_comb begin
    s = cur;
    if (item.start_of_string) begin
      s.phase         = PH_LEAD;
      s.accumulator   = '0;
      s.minus_seen    = 1'b0;
      s.active_base   = base_setting;
      s.char_position = '0;
    end

    handled    = (s.phase == PH_DONE);
    do_advance = 1'b0;
    emit       = 1'b0;
    result     = '0;
    prod       = '0;
    sum        = '0;

    if (!handled && s.phase == PH_LEAD) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
        do_advance = 1'b1;
        handled    = 1'b1;
      end else begin
        s.phase = PH_SIGNED;
        if (c == CH_PLUS || c == CH_MINUS) begin
          s.minus_seen = (c == CH_MINUS);
          do_advance   = 1'b1;
          handled      = 1'b1;
        end
      end
    end

    if (!handled && s.phase == PH_SIGNED) begin
      if (s.active_base == BASE_DETECT) begin
        if (c == CH_ZERO) begin
          do_advance = 1'b1;
          s.phase    = PH_ZERO;
          handled    = 1'b1;
        end else begin
          s.active_base = BASE_DEC;
        end
      end
      if (!handled) begin
        s.phase = PH_DIGITS;
      end
    end

    if (!handled && s.phase == PH_ZERO) begin
      s.phase = PH_DIGITS;
      if (c == CH_LX || c == CH_UX) begin
        s.active_base = BASE_HEX;
        do_advance    = 1'b1;
        handled       = 1'b1;
      end else begin
        s.active_base = BASE_OCT;
      end
    end

    if (!handled) begin
      // digit phase: one multiply-add with a carry-out check
      prod = PROD_WIDTH'(s.accumulator) * PROD_WIDTH'(s.active_base);
      sum  = (VALUE_WIDTH+1)'(prod[VALUE_WIDTH-1:0]) + (VALUE_WIDTH+1)'(dg.value);
      if (dg.valid && c != CH_NUL && dg.value < s.active_base) begin
        if ((|prod[PROD_WIDTH-1:VALUE_WIDTH]) || sum[VALUE_WIDTH]) begin
          emit              = 1'b1;
          result.value      = VALUE_MAX;
          result.overflowed = 1'b1;
          s.phase           = PH_DONE;
        end else begin
          s.accumulator = sum[VALUE_WIDTH-1:0];
          do_advance    = 1'b1;
        end
      end else begin
        emit              = 1'b1;
        result.value      = s.minus_seen ? (VALUE_WIDTH'(0) - s.accumulator) : s.accumulator;
        result.overflowed = 1'b0;
        s.phase           = PH_DONE;
      end
    end

    // offset reflects the position before this character
    result.end_offset = offset_out(s.char_position);

    pos_inc = s.char_position + 1'b1;
    if (do_advance && s.char_position != POS_MAX) begin
      s.char_position = pos_inc;
    end

    next = s;
  end

endmodule

### hdl/ascp_out_reg.sv
// ----------------------------------------------------------------------------
// ascp_out_reg
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module ascp_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  ascp_pkg::result_item_t load_data,
  input  logic                   ready,
  output logic                   valid,
  output ascp_pkg::result_item_t data,
  output logic                   free
);
  import ascp_pkg::*;

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming ASCII to unsigned parser. Strings go in
// one character per transaction; a model of the parser inside the bench predicts
// each result and a checker compares it with what the core returns.
// ----------------------------------------------------------------------------
module tb;
  import ascp_pkg::*;

  localparam int          QUIET_LIMIT  = 4000;
  localparam int          DRAIN_CYCLES = 6;
  localparam int unsigned NO_DIGIT     = 255;
  localparam logic [PADDR_WIDTH-1:0] BASE_SETTING_ADDR = {REG_BASE_SETTING, 2'b00};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   char_valid = 1'b0;
  logic                   char_ready;
  char_item_t             char_data = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_item_t           result_data;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr = '0;
  logic [PDATA_WIDTH-1:0] pwdata = '0;
  logic [PDATA_WIDTH-1:0] prdata;
  logic                   pready;

  // parser model state
  phase_t       parse_ph = PH_DONE;
  value_t       parse_acc = '0;
  logic         parse_minus = 1'b0;
  base_t        parse_base = '0;
  pos_t         parse_pos = '0;
  base_t        base_cfg = '0;

  result_item_t pending_results[$];
  result_item_t got_want;
  int           error_count = 0;
  int           idle_pct = 18;
  int           chars_sent = 0;
  int           quiet_cycles = 0;

  ascii_to_unsigned_parser_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string msg);
    error_count++;
    if (error_count <= 100) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int unsigned char_digit(input char_t c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_UA && c <= CH_UZ) return c - CH_UA + LETTER_OFFSET;
    if (c >= CH_LA && c <= CH_LZ) return c - CH_LA + LETTER_OFFSET;
    return NO_DIGIT;
  endfunction

  function automatic char_item_t char_item(input char_t c, input logic s);
    return char_item_t'{char_code: c, start_of_string: s};
  endfunction

  task automatic bump_pos();
    if (parse_pos != POS_MAX) parse_pos++;
  endtask

  task automatic post_result(input value_t v, input logic ovf);
    pending_results.push_back(result_item_t'{value: v, end_offset: parse_pos,
                                             overflowed: ovf});
    parse_ph = PH_DONE;
  endtask

  // Advance the parser model by one character and queue any result it ends with.
  task automatic predict_parse(input char_item_t it);
    char_t       c;
    int unsigned d;
    value_t      b;
    value_t      m;
    c = it.char_code;
    if (it.start_of_string) begin
      parse_ph    = PH_LEAD;
      parse_acc   = '0;
      parse_minus = 1'b0;
      parse_base  = base_cfg;
      parse_pos   = '0;
    end
    if (parse_ph == PH_DONE) return;
    if (parse_ph == PH_LEAD) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
        bump_pos();
        return;
      end
      parse_ph = PH_SIGNED;
      if (c == CH_PLUS || c == CH_MINUS) begin
        parse_minus = (c == CH_MINUS);
        bump_pos();
        return;
      end
    end
    if (parse_ph == PH_SIGNED) begin
      if (parse_base == BASE_DETECT) begin
        if (c == CH_ZERO) begin
          bump_pos();
          parse_ph = PH_ZERO;
          return;
        end
        parse_base = BASE_DEC;
      end
      parse_ph = PH_DIGITS;
    end
    if (parse_ph == PH_ZERO) begin
      parse_ph = PH_DIGITS;
      if (c == CH_LX || c == CH_UX) begin
        parse_base = BASE_HEX;
        bump_pos();
        return;
      end
      parse_base = BASE_OCT;
    end
    d = char_digit(c);
    if (c != CH_NUL && d < parse_base) begin
      b = value_t'(parse_base);
      if (parse_acc > VALUE_MAX / b) begin
        post_result(VALUE_MAX, 1'b1);
        return;
      end
      m = parse_acc * b;
      if (value_t'(d) > VALUE_MAX - m) begin
        post_result(VALUE_MAX, 1'b1);
        return;
      end
      parse_acc = m + value_t'(d);
      bump_pos();
      return;
    end
    post_result(parse_minus ? -parse_acc : parse_acc, 1'b0);
  endtask

  // Send one character; valid stays high after the transaction so that a
  // following send without a gap keeps it up.
  task automatic send_char(input char_item_t it);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= it;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    predict_parse(it);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(char_item(char_t'(s[i]), i == 0));
  endtask

  task automatic send_nul();
    send_char(char_item(CH_NUL, 1'b0));
  endtask

  // Drop valid and wait until every result has come back and the pipe is empty.
  task automatic settle();
    char_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_base(input int unsigned b);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BASE_SETTING_ADDR;
    pwdata  <= PDATA_WIDTH'(b);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    base_cfg = base_t'(b);
  endtask

  task automatic test_sign_and_prefix();
    set_base(BASE_DETECT);
    send_text(" -0x1F");
    send_nul();
    send_text("0179");
    // dropped by the next start
    send_text("4");
    send_text("0xg");
    send_text("+");
    send_nul();
    // ignored: parse already ended
    send_char(char_item(CH_NINE, 1'b0));
  endtask

  task automatic test_explicit_bases();
    set_base(1);
    send_text("01");
    set_base(BASE_HEX);
    send_text("0x");
    set_base(63);
    send_text("Zz{");
  endtask

  task automatic random_phase(input int unsigned b, input int n, input int pct);
    string       edge_texts[5];
    string       sgn;
    char_t       q[$];
    int unsigned eff;
    int unsigned v;
    int          r;
    int          p;
    int          len;
    int          stop_at;
    edge_texts = '{"18446744073709551615", "18446744073709551616",
                   "99999999999999999999", "0xffffffffffffffff",
                   "0x10000000000000000"};
    set_base(b);
    idle_pct = pct;
    stop_at = chars_sent + n;
    while (chars_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 8) begin
        repeat ($urandom_range(1, 6))
          send_char(char_item(char_t'($urandom_range(255)), $urandom_range(99) < 30));
      end else if (r < 14) begin
        sgn = "";
        if ($urandom_range(1)) sgn = "-";
        send_text({sgn, edge_texts[$urandom_range(4)]});
        send_nul();
      end else begin
        q.delete();
        repeat ($urandom_range(0, 3)) begin
          p = $urandom_range(2);
          q.push_back(p == 0 ? CH_SPACE : (p == 1 ? CH_TAB : CH_NL));
        end
        if ($urandom_range(1)) q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        eff = base_cfg;
        p = $urandom_range(9);
        if (p < 3) begin
          q.push_back(CH_ZERO);
          q.push_back($urandom_range(1) ? CH_LX : CH_UX);
          if (eff == BASE_DETECT) eff = BASE_HEX;
        end else if (p < 5) begin
          q.push_back(CH_ZERO);
          if (eff == BASE_DETECT) eff = BASE_OCT;
        end
        if (eff == BASE_DETECT) eff = BASE_DEC;
        if (eff > 36) eff = 36;
        len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 8);
        repeat (len) begin
          if ($urandom_range(99) < 95) begin
            v = $urandom_range(eff - 1);
            if (v < 10) q.push_back(char_t'(CH_ZERO + v));
            else if ($urandom_range(1)) q.push_back(char_t'(CH_UA + v - 10));
            else q.push_back(char_t'(CH_LA + v - 10));
          end else begin
            q.push_back(char_t'($urandom_range(255)));
          end
        end
        p = $urandom_range(9);
        // no terminator: the next start drops this parse
        if (p < 6) q.push_back(CH_NUL);
        else if (p < 8) q.push_back(char_t'($urandom_range(255)));
        for (int i = 0; i < q.size(); i++) send_char(char_item(q[i], i == 0));
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 2))
            send_char(char_item(char_t'($urandom_range(255)), 1'b0));
      end
    end
  endtask

  task automatic test_random_strings();
    random_phase(BASE_DETECT, 200, 18);
    random_phase(BASE_DEC, 200, 18);
    // long stretch with both sides always ready
    random_phase(BASE_HEX, 300, 0);
    random_phase(BASE_OCT, 150, 18);
    random_phase(2, 150, 18);
    random_phase(36, 200, 18);
    random_phase(1, 100, 18);
    random_phase(63, 200, 18);
    random_phase($urandom_range(3, 62), 150, 18);
    random_phase(BASE_DETECT, 150, 18);
  endtask

  always @(posedge clk) begin
    if (idle_pct == 0) result_ready <= 1'b1;
    else result_ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        report("result transaction with nothing expected");
      end else begin
        got_want = pending_results.pop_front();
        if (result_data.value !== got_want.value)
          report($sformatf("value %h, expected %h", result_data.value, got_want.value));
        if (result_data.end_offset !== got_want.end_offset)
          report($sformatf("end_offset %0d, expected %0d",
                           result_data.end_offset, got_want.end_offset));
        if (result_data.overflowed !== got_want.overflowed)
          report($sformatf("overflowed %b, expected %b",
                           result_data.overflowed, got_want.overflowed));
      end
    end
  end

  // Hang detection: count cycles in which no transaction of any kind completes.
  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (result_valid && result_ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_sign_and_prefix();
    test_explicit_bases();
    test_random_strings();
    settle();
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
hdl/ascp_pkg.sv
hdl/ascp_cfg.sv
hdl/ascp_step.sv
hdl/ascp_out_reg.sv
hdl/ascii_to_unsigned_parser_core.sv
tb/tb.sv
